/* hw/rtl/slkt_pkg.sv */
// Shared types and constants of the sorted leaf key table.
// Used by slkt_cell, sorted_leaf_key_table_unit and tb_top; depends on nothing.
package slkt_pkg;

	// Fixed field widths of the item ports.
	localparam int OP_BITS = 2;
	localparam int KEY_BITS = 32;
	localparam int VALUE_PORT_BITS = 64;
	localparam int STATUS_BITS = 2;
	localparam int FIELD_BITS = 5;

	// Defaults for the top-level parameters.
	localparam int CELLS_DEFAULT = 16;
	localparam int VALUE_BITS_DEFAULT = 64;

	// Operation codes.
	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_BITS-1:0] OP_DELETE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_MISSING = 2'd2;

	// Command broadcast from the control logic to every cell.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} slkt_ctrl_t;

endpackage

/* hw/rtl/sorted_leaf_key_table_unit.sv */
// Top level of the sorted leaf key table: control, result register and the cell chain.
// Depends on slkt_pkg and slkt_cell.
//
// A key-ordered table of CELLS key/value cells, like one B+tree leaf. Each item
// is first captured; then, once the output register is free, every cell compares
// its key against the search key in parallel, and the chain shifts up (successful
// insert) or down (successful delete) by one place while the result is written to
// the output register. No new item is taken while one executes, but one is taken
// while the previous result still waits on the output.
module sorted_leaf_key_table_unit import slkt_pkg::*; #(
	parameter int CELLS = CELLS_DEFAULT,
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [OP_BITS-1:0]         op,
	input  logic [KEY_BITS-1:0]        key,
	input  logic [VALUE_PORT_BITS-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_BITS-1:0]     status,
	output logic [VALUE_PORT_BITS-1:0] found_value,
	output logic [FIELD_BITS-1:0]      position,
	output logic [FIELD_BITS-1:0]      entry_count
);

	localparam int CW = $clog2(CELLS + 1);
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic                  state_q;
	logic [OP_BITS-1:0]    op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [CW-1:0]         count_q;

	logic                       out_valid_q;
	logic [STATUS_BITS-1:0]     status_q;
	logic [VALUE_PORT_BITS-1:0] found_value_q;
	logic [FIELD_BITS-1:0]      position_q;
	logic [FIELD_BITS-1:0]      entry_count_q;

	logic [KEY_BITS-1:0]   cell_key [CELLS];
	logic [VALUE_BITS-1:0] cell_value [CELLS];
	logic [CELLS-1:0]      stop;
	logic [CELLS-1:0]      prev_stop;
	logic [CELLS-1:0]      match;
	logic [CELLS-1:0]      at_bound;

	slkt_ctrl_t            ctrl;
	logic                  fire;
	logic                  full;
	logic                  found;
	logic [CW-1:0]         bound;
	logic [VALUE_BITS-1:0] hit_value;
	logic [STATUS_BITS-1:0] next_status;
	logic [VALUE_BITS-1:0] next_value;
	logic [CW-1:0]         next_pos;
	logic [CW-1:0]         next_count;
	logic [CW+FIELD_BITS-1:0]        pos_wide;
	logic [CW+FIELD_BITS-1:0]        count_wide;
	logic [VALUE_BITS+VALUE_PORT_BITS-1:0] value_wide;

	assign in_ready = (state_q == ST_IDLE);
	assign fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready);
	assign full = (count_q == CW'(CELLS));

	// The cell chain; each cell sees its neighbors' contents and the stop flag below it.
	assign prev_stop = {stop[CELLS-2:0], 1'b0};
	assign at_bound = stop & ~prev_stop;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic [KEY_BITS-1:0]   left_key;
		logic [VALUE_BITS-1:0] left_value;
		logic [KEY_BITS-1:0]   right_key;
		logic [VALUE_BITS-1:0] right_value;

		if (i == 0) begin : g_first
			assign left_key = key_q;
			assign left_value = value_q;
		end else begin : g_inner_l
			assign left_key = cell_key[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == CELLS - 1) begin : g_last
			assign right_key = cell_key[i];
			assign right_value = cell_value[i];
		end else begin : g_inner_r
			assign right_key = cell_key[i+1];
			assign right_value = cell_value[i+1];
		end

		slkt_cell #(
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (CW'(i) < count_q),
			.search_key (key_q),
			.new_value  (value_q),
			.prev_stop  (prev_stop[i]),
			.left_key   (left_key),
			.left_value (left_value),
			.right_key  (right_key),
			.right_value(right_value),
			.stop       (stop[i]),
			.match      (match[i]),
			.cell_key   (cell_key[i]),
			.cell_value (cell_value[i])
		);
	end

	// Encode the one-hot bound position and pick the value of a matching cell there.
	always_comb begin
		bound = '0;
		hit_value = '0;
		for (int i = 0; i < CELLS; i++) begin
			if (at_bound[i]) begin
				bound = bound | CW'(i);
			end
			if (at_bound[i] && match[i]) begin
				hit_value = hit_value | cell_value[i];
			end
		end
		if (!stop[CELLS-1]) begin
			bound = CW'(CELLS);
		end
	end

	assign found = |(at_bound & match);

	// Decide the result and the chain command for the captured item.
	always_comb begin
		ctrl = '0;
		next_status = STATUS_MISSING;
		next_value = '0;
		next_pos = bound;
		next_count = count_q;
		case (op_q)
			OP_INSERT: begin
				if (full) begin
					next_status = STATUS_FULL;
				end else begin
					next_status = STATUS_DONE;
					ctrl.shift_up = fire;
					next_count = count_q + CW'(1);
				end
			end
			OP_LOOKUP: begin
				if (found) begin
					next_status = STATUS_DONE;
					next_value = hit_value;
				end
			end
			OP_DELETE: begin
				if (found) begin
					next_status = STATUS_DONE;
					ctrl.shift_down = fire;
					next_count = count_q - CW'(1);
				end
			end
			default: begin
				next_pos = '0;
			end
		endcase
	end

	// Fit internal widths to the fixed port widths.
	assign pos_wide = {{FIELD_BITS{1'b0}}, next_pos};
	assign count_wide = {{FIELD_BITS{1'b0}}, next_count};
	assign value_wide = {{VALUE_PORT_BITS{1'b0}}, next_value};

	// Control state: item capture, execute step, the occupied count and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				state_q <= ST_EXEC;
			end else if (fire) begin
				state_q <= ST_IDLE;
			end
			if (fire) begin
				count_q <= next_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured item fields.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op;
			key_q <= key;
			value_q <= value[VALUE_BITS-1:0];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= next_status;
			found_value_q <= value_wide[VALUE_PORT_BITS-1:0];
			position_q <= pos_wide[FIELD_BITS-1:0];
			entry_count_q <= count_wide[FIELD_BITS-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_value = found_value_q;
	assign position = position_q;
	assign entry_count = entry_count_q;

endmodule

/* hw/rtl/slkt_cell.sv */
// One key/value cell of the sorted leaf key table chain.
// Depends on slkt_pkg for the key width and the command struct.
module slkt_cell import slkt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
	input  logic                  clk,
	input  slkt_ctrl_t            ctrl,
	input  logic                  occupied,
	input  logic [KEY_BITS-1:0]   search_key,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic                  prev_stop,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [KEY_BITS-1:0]   right_key,
	input  logic [VALUE_BITS-1:0] right_value,
	output logic                  stop,
	output logic                  match,
	output logic [KEY_BITS-1:0]   cell_key,
	output logic [VALUE_BITS-1:0] cell_value
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// The lower bound is the first cell that is empty or holds a key not below the search key.
	assign stop = !occupied || (key_q >= search_key);
	assign match = occupied && (key_q == search_key);
	assign cell_key = key_q;
	assign cell_value = value_q;

	// Insert moves cells above the bound up one place; delete pulls cells from the bound down.
	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			if (prev_stop) begin
				key_q <= left_key;
				value_q <= left_value;
			end else if (stop) begin
				key_q <= search_key;
				value_q <= new_value;
			end
		end else if (ctrl.shift_down && stop) begin
			key_q <= right_key;
			value_q <= right_value;
		end
	end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_leaf_key_table_unit, a key-ordered table of key/value cells.
// Depends on slkt_pkg and the RTL; a shadow table predicts every reply to an insert, lookup or delete.

module tb_top;
	import slkt_pkg::*;

	localparam int TABLE_CELLS = CELLS_DEFAULT;
	localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 680;
	localparam int HOLD_AT = 250;
	localparam int LONG_HOLD = 120;
	localparam int STALL_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 10;

	// One reply of the block, as the shadow table predicts it.
	typedef struct packed {
		logic [STATUS_BITS-1:0]     status;
		logic [VALUE_PORT_BITS-1:0] found_value;
		logic [FIELD_BITS-1:0]      position;
		logic [FIELD_BITS-1:0]      entry_count;
	} leaf_reply_t;

	// Shadow copy of the leaf table plus the replies still owed by the block.
	class leaf_table_scoreboard;
		logic [KEY_BITS-1:0]        shadow_keys[TABLE_CELLS];
		logic [VALUE_PORT_BITS-1:0] shadow_values[TABLE_CELLS];
		int                         shadow_count = 0;
		leaf_reply_t                awaited_replies[$];
		int                         errors = 0;

		function int pending();
			return awaited_replies.size();
		endfunction

		// Apply one accepted item to the shadow table and queue the reply it causes.
		function void apply_command(logic [OP_BITS-1:0] cmd, logic [KEY_BITS-1:0] k,
				logic [VALUE_PORT_BITS-1:0] v);
			leaf_reply_t r;
			int slot;
			r.status = STATUS_MISSING;
			r.found_value = '0;
			r.position = '0;
			// The first cell whose key is not below the search key.
			slot = shadow_count;
			for (int i = shadow_count - 1; i >= 0; i--) begin
				if (shadow_keys[i] >= k)
					slot = i;
			end
			if (cmd == OP_INSERT) begin
				r.position = FIELD_BITS'(slot);
				if (shadow_count >= TABLE_CELLS) begin
					r.status = STATUS_FULL;
				end else begin
					for (int i = shadow_count; i > slot; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_values[i] = shadow_values[i-1];
					end
					shadow_keys[slot] = k;
					shadow_values[slot] = v;
					shadow_count++;
					r.status = STATUS_DONE;
				end
			end else if (cmd == OP_LOOKUP || cmd == OP_DELETE) begin
				r.position = FIELD_BITS'(slot);
				if (slot < shadow_count && shadow_keys[slot] == k) begin
					r.status = STATUS_DONE;
					if (cmd == OP_LOOKUP) begin
						r.found_value = shadow_values[slot];
					end else begin
						for (int i = slot; i + 1 < shadow_count; i++) begin
							shadow_keys[i] = shadow_keys[i+1];
							shadow_values[i] = shadow_values[i+1];
						end
						shadow_count--;
					end
				end
			end
			r.entry_count = FIELD_BITS'(shadow_count);
			awaited_replies.insert(awaited_replies.size(), r);
		endfunction

		function void compare_field(string name, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				errors++;
				$display("%0t ns: %s expected %0h, got %0h", $time, name, exp, act);
			end
		endfunction

		// Compare one accepted reply with the oldest prediction.
		function void check_reply(leaf_reply_t got);
			leaf_reply_t exp;
			if (awaited_replies.size() == 0) begin
				errors++;
				$display("%0t ns: reply with nothing awaited, status %0h position %0d",
					$time, got.status, got.position);
				return;
			end
			exp = awaited_replies.pop_front();
			compare_field("status", 64'(exp.status), 64'(got.status));
			compare_field("found_value", exp.found_value, got.found_value);
			compare_field("position", 64'(exp.position), 64'(got.position));
			compare_field("entry_count", 64'(exp.entry_count), 64'(got.entry_count));
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_BITS-1:0]         op = OP_LOOKUP;
	logic [KEY_BITS-1:0]        key = '0;
	logic [VALUE_PORT_BITS-1:0] value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [STATUS_BITS-1:0]     status;
	logic [VALUE_PORT_BITS-1:0] found_value;
	logic [FIELD_BITS-1:0]      position;
	logic [FIELD_BITS-1:0]      entry_count;

	leaf_table_scoreboard book = new();
	bit sender_calm = 1'b0;

	sorted_leaf_key_table_unit u_dut (.*);

	// Clock: 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offer one item after a random gap (none while the sender is calm) and hold it until the block takes it.
	task automatic send_item(input logic [OP_BITS-1:0] cmd, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_PORT_BITS-1:0] v);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		key <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		book.apply_command(cmd, k, v);
	endtask

	// Stop offering items until every awaited reply has come back.
	task automatic drain_replies();
		in_valid <= 1'b0;
		do @(posedge clk); while (book.pending() != 0);
	endtask

	// Reply checker.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			book.check_reply('{status, found_value, position, entry_count});
	end

	// Reply sink: random stalls, calm stretches and one long hold-off.
	initial begin : reply_sink
		int gap;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		forever begin
			if (taken % 40 == 0)
				calm = ($urandom_range(0, 2) == 0);
			if (taken == HOLD_AT)
				gap = LONG_HOLD;
			else
				gap = calm ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t ns: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Stimulus: directed corner cases, then random traffic.
	initial begin : stimulus
		logic [KEY_BITS-1:0] key_pool[8];
		logic [OP_BITS-1:0]  cmd;
		logic [KEY_BITS-1:0] k;
		int insert_bias;
		int roll;
		key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_1234, 32'h0000_1235, 32'hDEAD_BEEF};
		insert_bias = 50;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: misses and the unused op code.
		send_item(OP_LOOKUP, 32'h0000_0005, '1);
		send_item(OP_DELETE, 32'h0000_0005, '1);
		send_item(OP_UNUSED, 32'hFFFF_FFFF, '1);
		// Extreme keys and values, then a duplicate key.
		send_item(OP_INSERT, 32'hFFFF_FFFF, '1);
		send_item(OP_INSERT, 32'h0000_0000, '0);
		send_item(OP_INSERT, 32'h8000_0000, 64'h5555_5555_5555_5555);
		send_item(OP_INSERT, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
		send_item(OP_LOOKUP, 32'h8000_0000, '0);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
		send_item(OP_DELETE, 32'h8000_0000, '1);
		send_item(OP_LOOKUP, 32'h8000_0000, '0);
		// Fill every cell, then an insert into the full table.
		for (int i = 0; i < TABLE_CELLS - 3; i++)
			send_item(OP_INSERT, $urandom(), {$urandom(), $urandom()});
		send_item(OP_INSERT, 32'h8000_0000, '1);
		send_item(OP_LOOKUP, 32'hFFFF_FFFF, '0);
		send_item(OP_DELETE, 32'h0000_0000, '0);
		send_item(OP_UNUSED, 32'h0000_0000, '0);
		drain_replies();

		// Random traffic, mostly on a small key pool so that hits and duplicates are common.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				insert_bias = $urandom_range(20, 80);
			if (n % 40 == 0)
				sender_calm = ($urandom_range(0, 2) == 0);
			if (n == RANDOM_ITEMS / 2)
				drain_replies();
			roll = $urandom_range(0, 99);
			if (roll < 3)
				cmd = OP_UNUSED;
			else if ($urandom_range(0, 99) < insert_bias)
				cmd = OP_INSERT;
			else if ($urandom_range(0, 1) == 0)
				cmd = OP_LOOKUP;
			else
				cmd = OP_DELETE;
			if ($urandom_range(0, 9) < 7)
				k = key_pool[$urandom_range(0, 7)];
			else
				k = $urandom();
			send_item(cmd, k, {$urandom(), $urandom()});
		end
		in_valid <= 1'b0;

		// Wait for the last replies, then let the block settle.
		do @(posedge clk); while (book.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (book.errors == 0 && book.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/slkt_pkg.sv
hw/rtl/slkt_cell.sv
hw/rtl/sorted_leaf_key_table_unit.sv
tb/sv/tb_top.sv
